/* hdl/gdad_pkg.sv */
// ----------------------------------------------------------------------------
// gdad_pkg
// Shared types, microcode table and calendar helpers for the date adder.
// ----------------------------------------------------------------------------
package gdad_pkg;

  localparam int unsigned DayW    = 5;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned YearW   = 14;
  localparam int unsigned OffsetW = 17;
  localparam int unsigned AccW    = 18;
  localparam int unsigned YrAccW  = 16;
  localparam int unsigned StepW   = 3;
  localparam int unsigned Mod25W  = 5;
  localparam int unsigned QuotW   = 10;

  // floor(y * RECIP_25 / 2^RECIP_SHIFT) == floor(y / 25) for every 14-bit y
  localparam logic [15:0] RECIP_25    = 16'd41944;
  localparam int unsigned RECIP_SHIFT = 20;

  localparam logic [MonthW-1:0] MON_JAN = 4'd1;
  localparam logic [MonthW-1:0] MON_FEB = 4'd2;
  localparam logic [MonthW-1:0] MON_APR = 4'd4;
  localparam logic [MonthW-1:0] MON_JUN = 4'd6;
  localparam logic [MonthW-1:0] MON_SEP = 4'd9;
  localparam logic [MonthW-1:0] MON_NOV = 4'd11;
  localparam logic [MonthW-1:0] MON_DEC = 4'd12;

  localparam logic signed [YrAccW-1:0] YEAR_MIN = 16'sd1;
  localparam logic signed [YrAccW-1:0] YEAR_MAX = 16'sd9999;

  typedef logic [StepW-1:0] step_t;

  localparam step_t STEP_IDLE = 3'd0;
  localparam step_t STEP_MOD  = 3'd1;
  localparam step_t STEP_FWD  = 3'd2;
  localparam step_t STEP_BWD  = 3'd3;
  localparam step_t STEP_DONE = 3'd4;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_MOD,
    OP_FWD,
    OP_BWD,
    OP_DONE
  } op_e;

  typedef enum logic [1:0] {
    C_ALWAYS,
    C_IDLE,
    C_OVER,
    C_UNDER
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    op_e op;
  } ctrl_t;

  typedef struct packed {
    logic over;
    logic under;
  } flags_t;

  // Condition true: jump to target, else fall through to next step.
  function automatic uword_t ucode(input step_t step);
    uword_t w;
    case (step)
      STEP_IDLE: w = '{op: OP_LOAD, cond: C_IDLE,   target: STEP_IDLE};
      STEP_MOD:  w = '{op: OP_MOD,  cond: C_ALWAYS, target: STEP_FWD};
      STEP_FWD:  w = '{op: OP_FWD,  cond: C_OVER,   target: STEP_FWD};
      STEP_BWD:  w = '{op: OP_BWD,  cond: C_UNDER,  target: STEP_BWD};
      STEP_DONE: w = '{op: OP_DONE, cond: C_ALWAYS, target: STEP_IDLE};
      default:   w = '{op: OP_NOP,  cond: C_ALWAYS, target: STEP_IDLE};
    endcase
    return w;
  endfunction

  // ylow: low four year bits, r25: year mod 25
  function automatic logic is_leap(input logic [3:0] ylow, input logic [Mod25W-1:0] r25);
    return (ylow[1:0] == 2'd0) && ((r25 != '0) || (ylow == 4'd0));
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m, input logic leap);
    logic [DayW-1:0] len;
    case (m)
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      MON_FEB: len = leap ? 5'd29 : 5'd28;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* hdl/gdad_sequencer.sv */
// ----------------------------------------------------------------------------
// gdad_sequencer
// Step counter over the microcode table with conditional jumps.
// ----------------------------------------------------------------------------
module gdad_sequencer import gdad_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start,
  input  flags_t flags_i,
  output ctrl_t  ctrl_o,
  output logic   busy
);

  step_t  step_q, step_d;
  uword_t word;
  logic   take;

  always_comb begin
    word = ucode(step_q);
    case (word.cond)
      C_ALWAYS: take = 1'b1;
      C_IDLE:   take = !start;
      C_OVER:   take = flags_i.over;
      C_UNDER:  take = flags_i.under;
      default:  take = 1'b1;
    endcase
    step_d = take ? word.target : step_q + step_t'(1);
  end

  always_comb begin
    ctrl_o.op = word.op;
    if (word.op == OP_LOAD && !start) begin
      ctrl_o.op = OP_NOP;
    end
  end

  assign busy = (step_q != STEP_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

`ifndef ASSERT_OFF
  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.op == OP_LOAD) |-> (step_q == STEP_IDLE && start))
    else $error("load outside idle step");
  a_idle_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == STEP_DONE) |=> (step_q == STEP_IDLE))
    else $error("done step not followed by idle");
  a_accept_to_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (step_q == STEP_MOD))
    else $error("accepted beat did not enter residue step");
`endif

endmodule

/* hdl/gdad_datapath.sv */
// ----------------------------------------------------------------------------
// gdad_datapath
// Day accumulator, month/year walk registers and the month length unit.
// ----------------------------------------------------------------------------
module gdad_datapath import gdad_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ctrl_t                     ctrl_i,
  input  logic [DayW-1:0]           start_day_i,
  input  logic [MonthW-1:0]         start_month_i,
  input  logic [YearW-1:0]          start_year_i,
  input  logic signed [OffsetW-1:0] day_offset_i,
  output flags_t                    flags_o,
  output logic                      done_o,
  output logic [DayW-1:0]           end_day_o,
  output logic [MonthW-1:0]         end_month_o,
  output logic [YearW-1:0]          end_year_o,
  output logic                      year_out_of_range_o
);

  logic signed [AccW-1:0]   day_q, day_d;
  logic [MonthW-1:0]        month_q, month_d;
  logic signed [YrAccW-1:0] year_q, year_d;
  logic [Mod25W-1:0]        mod_q, mod_d;
  logic [QuotW-1:0]         quot_q, quot_d;
  logic                     done_q, done_d;
  logic [DayW-1:0]          eday_q, eday_d;
  logic [MonthW-1:0]        emon_q, emon_d;
  logic [YearW-1:0]         eyear_q, eyear_d;
  logic                     err_q, err_d;

  logic [29:0]              recip_prod;
  logic [YearW-1:0]         quot25, resid;
  logic                     wrap_up, wrap_dn;
  logic [MonthW-1:0]        inc_month, dec_month;
  logic signed [YrAccW-1:0] inc_year, dec_year;
  logic [Mod25W-1:0]        inc_mod, dec_mod;
  logic [DayW-1:0]          len_cur, len_dec;
  logic                     year_ok;

  assign recip_prod = 30'(start_year_i) * 30'(RECIP_25);
  assign quot25 = {quot_q, 4'b0} + {1'b0, quot_q, 3'b0} + {4'b0, quot_q};
  assign resid  = year_q[YearW-1:0] - quot25;

  assign wrap_up   = (month_q >= MON_DEC);
  assign wrap_dn   = (month_q <= MON_JAN);
  assign inc_mod   = (mod_q == Mod25W'(24)) ? '0 : mod_q + Mod25W'(1);
  assign dec_mod   = (mod_q == '0) ? Mod25W'(24) : mod_q - Mod25W'(1);
  assign inc_month = wrap_up ? MON_JAN : month_q + MonthW'(1);
  assign dec_month = wrap_dn ? MON_DEC : month_q - MonthW'(1);
  assign inc_year  = wrap_up ? year_q + YrAccW'(1) : year_q;
  assign dec_year  = wrap_dn ? year_q - YrAccW'(1) : year_q;

  assign len_cur = month_len(month_q, is_leap(year_q[3:0], mod_q));
  assign len_dec = month_len(dec_month,
                             is_leap(dec_year[3:0], wrap_dn ? dec_mod : mod_q));

  assign flags_o.over  = (day_q > $signed({{(AccW-DayW){1'b0}}, len_cur}));
  assign flags_o.under = (day_q < $signed(AccW'(1)));

  assign year_ok = (year_q >= YEAR_MIN) && (year_q <= YEAR_MAX);

  always_comb begin
    day_d   = day_q;
    month_d = month_q;
    year_d  = year_q;
    mod_d   = mod_q;
    quot_d  = quot_q;
    done_d  = 1'b0;
    eday_d  = eday_q;
    emon_d  = emon_q;
    eyear_d = eyear_q;
    err_d   = err_q;
    case (ctrl_i.op)
      OP_LOAD: begin
        day_d   = $signed({{(AccW-DayW){1'b0}}, start_day_i})
                + AccW'(day_offset_i);
        month_d = start_month_i;
        year_d  = $signed({{(YrAccW-YearW){1'b0}}, start_year_i});
        quot_d  = recip_prod[RECIP_SHIFT +: QuotW];
      end
      OP_MOD: begin
        mod_d = resid[Mod25W-1:0];
      end
      OP_FWD: begin
        if (flags_o.over) begin
          day_d   = day_q - $signed({{(AccW-DayW){1'b0}}, len_cur});
          month_d = inc_month;
          year_d  = inc_year;
          mod_d   = wrap_up ? inc_mod : mod_q;
        end
      end
      OP_BWD: begin
        if (flags_o.under) begin
          day_d   = day_q + $signed({{(AccW-DayW){1'b0}}, len_dec});
          month_d = dec_month;
          year_d  = dec_year;
          mod_d   = wrap_dn ? dec_mod : mod_q;
        end
      end
      OP_DONE: begin
        done_d  = 1'b1;
        err_d   = !year_ok;
        eday_d  = year_ok ? day_q[DayW-1:0] : '0;
        emon_d  = year_ok ? month_q : '0;
        eyear_d = year_ok ? year_q[YearW-1:0] : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    day_q   <= day_d;
    month_q <= month_d;
    year_q  <= year_d;
    mod_q   <= mod_d;
    quot_q  <= quot_d;
    eday_q  <= eday_d;
    emon_q  <= emon_d;
    eyear_q <= eyear_d;
    err_q   <= err_d;
  end

  assign done_o              = done_q;
  assign end_day_o           = eday_q;
  assign end_month_o         = emon_q;
  assign end_year_o          = eyear_q;
  assign year_out_of_range_o = err_q;

`ifndef ASSERT_OFF
  a_err_zero_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (year_out_of_range_o == (end_year_o == '0)))
    else $error("error flag and result year disagree");
  a_day_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !year_out_of_range_o) |-> (end_day_o != '0))
    else $error("valid result with zero day");
  a_walk_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == OP_DONE) |-> (!flags_o.over && !flags_o.under))
    else $error("walk ended with day outside month");
`endif

endmodule

/* hdl/gregorian_date_add_days.sv */
// ----------------------------------------------------------------------------
// gregorian_date_add_days
// Adds a signed day offset to a Gregorian date by walking month by month.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | start / busy         | start_day_i start_month_i start_year_i
//          |                      | day_offset_i
//  out     | done_o (1-cycle)     | end_day_o end_month_o end_year_o
//          |                      | year_out_of_range_o
//
//  A beat is taken when start is high and busy is low; busy then stays high
//  through the residue step, the forward and back month walks (one month
//  per cycle, worst case about 2160 months) and the done step.
//  done_o pulses in the first idle cycle, so a new beat can be taken then.
//  Reset is asynchronous, active low, and returns the step counter to idle.
//  Results cannot be stalled; done_o is one cycle wide.
// ----------------------------------------------------------------------------
module gregorian_date_add_days import gdad_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [DayW-1:0]           start_day_i,
  input  logic [MonthW-1:0]         start_month_i,
  input  logic [YearW-1:0]          start_year_i,
  input  logic signed [OffsetW-1:0] day_offset_i,
  output logic                      done_o,
  output logic [DayW-1:0]           end_day_o,
  output logic [MonthW-1:0]         end_month_o,
  output logic [YearW-1:0]          end_year_o,
  output logic                      year_out_of_range_o
);

  ctrl_t  ctrl;
  flags_t flags;

  gdad_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .flags_i (flags),
    .ctrl_o  (ctrl),
    .busy    (busy)
  );

  gdad_datapath u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ctrl_i              (ctrl),
    .start_day_i         (start_day_i),
    .start_month_i       (start_month_i),
    .start_year_i        (start_year_i),
    .day_offset_i        (day_offset_i),
    .flags_o             (flags),
    .done_o              (done_o),
    .end_day_o           (end_day_o),
    .end_month_o         (end_month_o),
    .end_year_o          (end_year_o),
    .year_out_of_range_o (year_out_of_range_o)
  );

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done strobe longer than one cycle");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");
`endif

endmodule
